### hdl/ilb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilb_pkg
// Shared codes, widths and the cell control type of the indexed list buffer.
// ----------------------------------------------------------------------------
package ilb_pkg;

   localparam int CMD_W      = 3;
   localparam int POS_W      = 6;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;

   localparam int DEPTH_DEF      = 64;
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int DEPTH_MAX      = 1024;
   localparam int CTL_W          = $clog2(DEPTH_MAX + 1);

   localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OVERWRITE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic             do_append;
      logic             do_insert;
      logic             do_remove;
      logic             do_write;
      logic [CTL_W-1:0] pos;
      logic [CTL_W-1:0] fill;
   } cell_ctl_type;

endpackage

### hdl/ilb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilb_req_if / ilb_rsp_if
// Valid/ready channels carrying list commands and their results.
// ----------------------------------------------------------------------------
interface ilb_req_if;
   logic                          valid;
   logic                          ready;
   logic [ilb_pkg::CMD_W-1:0]     command;
   logic [ilb_pkg::POS_W-1:0]     position;
   logic [ilb_pkg::VALUE_W-1:0]   value;

   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

interface ilb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ilb_pkg::VALUE_W-1:0]   read_data;
   logic [ilb_pkg::COUNT_W-1:0]   count;
   logic [ilb_pkg::STATUS_W-1:0]  status;

   modport source (output valid, read_data, count, status, input ready);
   modport sink   (input valid, read_data, count, status, output ready);
endinterface

### hdl/ilb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilb_cell
// One list slot: loads a new value, takes a neighbour's entry on a shift,
// or holds. Drives its entry onto the read bus when addressed.
// ----------------------------------------------------------------------------
module ilb_cell #(
   parameter int ELEM_WIDTH = 32,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  ilb_pkg::cell_ctl_type   ctl,
   input  logic [ELEM_WIDTH-1:0]   load_value,
   input  logic [ELEM_WIDTH-1:0]   lower_entry,
   input  logic [ELEM_WIDTH-1:0]   upper_entry,
   output logic [ELEM_WIDTH-1:0]   entry,
   output logic [ELEM_WIDTH-1:0]   read_entry
);
   import ilb_pkg::*;

   localparam logic [CTL_W-1:0] IDX = CTL_W'(INDEX);

   logic [ELEM_WIDTH-1:0] entry_ff;
   logic [ELEM_WIDTH-1:0] entry_in;
   logic                  at_pos;

   assign at_pos = (IDX == ctl.pos);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.do_append && IDX == ctl.fill) begin
         entry_in = load_value;
      end else if (ctl.do_write && at_pos) begin
         entry_in = load_value;
      end else if (ctl.do_insert && at_pos) begin
         entry_in = load_value;
      end else if (ctl.do_insert && IDX > ctl.pos && IDX <= ctl.fill) begin
         entry_in = lower_entry;
      end else if (ctl.do_remove && IDX >= ctl.pos) begin
         entry_in = upper_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign read_entry = at_pos ? entry_ff : '0;

endmodule

### hdl/indexed_list_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_buffer
// Fixed-depth ordered list built as a row of shifting cells.
//
// Usage: commands arrive on req_if (command, position, value) and each one
// produces exactly one result on rsp_if (read_data, count, status). A
// request is taken when valid and ready are high at a rising clock edge.
// Append, insert, remove, overwrite, read and clear each finish as a single
// step: every cell loads, shifts from a neighbour or holds in parallel,
// and the read value is selected from the cells into the result register.
// Each result is registered in the cycle after its request is taken;
// throughput is one request per cycle while the receiver takes results.
// Results sit in a single output register; ready on req_if stays high while
// that register is empty or being emptied, so a stalled receiver holds off
// further requests without losing any result.
// Synchronous reset empties the list (count zero) and marks the result
// register empty; entry contents are left as they are and are never visible
// before being written.
// ----------------------------------------------------------------------------
module indexed_list_buffer #(
   parameter int DEPTH      = ilb_pkg::DEPTH_DEF,
   parameter int ELEM_WIDTH = ilb_pkg::ELEM_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ilb_req_if.sink   req_if,
   ilb_rsp_if.source rsp_if
);
   import ilb_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    fill_in;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_data_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                accept;
   logic                full;
   logic                rd_ok;
   logic [STATUS_W-1:0] status;
   logic [CTL_W-1:0]    pos_ext;
   logic [CTL_W-1:0]    fill_ext;
   cell_ctl_type        ctl;
   logic [63:0]         val_wide;
   logic [ELEM_WIDTH-1:0] val_elem;
   logic [63:0]         rd_wide;

   logic [ELEM_WIDTH-1:0] cell_entry [DEPTH];
   logic [ELEM_WIDTH-1:0] cell_read  [DEPTH];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (fill_ff == DEPTH_C);
   assign pos_ext      = CTL_W'(req_if.position);
   assign fill_ext     = CTL_W'(fill_ff);
   assign val_wide     = 64'(req_if.value);
   assign val_elem     = val_wide[ELEM_WIDTH-1:0];

   always_comb begin
      ctl       = '0;
      ctl.pos   = pos_ext;
      ctl.fill  = fill_ext;
      status    = ST_OK;
      fill_in   = fill_ff;
      rd_ok     = 1'b0;
      case (req_if.command)
         CMD_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctl.do_append = accept;
               fill_in       = fill_ff + 1'b1;
            end
         end
         CMD_INSERT: begin
            if (pos_ext > fill_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ctl.do_insert = accept;
               fill_in       = fill_ff + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (pos_ext >= fill_ext) begin
               status = ST_RANGE;
            end else begin
               ctl.do_remove = accept;
               fill_in       = fill_ff - 1'b1;
            end
         end
         CMD_OVERWRITE: begin
            if (pos_ext >= fill_ext) begin
               status = ST_RANGE;
            end else begin
               ctl.do_write = accept;
            end
         end
         CMD_READ: begin
            if (pos_ext >= fill_ext) begin
               status = ST_RANGE;
            end else begin
               rd_ok = 1'b1;
            end
         end
         CMD_CLEAR: begin
            fill_in = '0;
         end
         default: begin
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] lower;
      logic [ELEM_WIDTH-1:0] upper;
      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_lower
         assign lower = cell_entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign upper = '0;
      end else begin : g_upper
         assign upper = cell_entry[i+1];
      end
      ilb_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .load_value  (val_elem),
         .lower_entry (lower),
         .upper_entry (upper),
         .entry       (cell_entry[i]),
         .read_entry  (cell_read[i])
      );
   end

   always_comb begin
      rd_wide = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_wide = rd_wide | 64'(cell_read[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rd_ok ? rd_wide[VALUE_W-1:0] : '0;
         rsp_count_ff  <= COUNT_W'(fill_in);
         rsp_status_ff <= status;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = rsp_data_ff;
   assign rsp_if.count     = rsp_count_ff;
   assign rsp_if.status    = rsp_status_ff;

`ifndef SYNTHESIS
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("list length beyond depth");

   a_append_grows : assert property (@(posedge clock) disable iff (reset)
      accept && req_if.command == CMD_APPEND && !full
      |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("append did not grow the list");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |-> fill_ff == DEPTH_C)
      else $error("full status with room left");

   a_range_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_data_ff == '0)
      else $error("data returned with error status");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      accept && req_if.command == CMD_CLEAR |=> fill_ff == '0)
      else $error("clear left entries");
`endif

endmodule

### verif/ilb_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilb_list_checker
// Watches the request and result channels of the indexed list buffer, keeps
// a shadow copy of the list, predicts the result of every accepted request
// and compares each accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ilb_list_checker (
   input  logic clock,
   input  logic reset,
   ilb_req_if   req_mon,
   ilb_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   import ilb_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEF;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_data;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } list_result_type;

   logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
   int                 shadow_fill = 0;
   list_result_type    expected_q [$];
   int                 errors = 0;

   function automatic list_result_type apply_list_command(
      input logic [CMD_W-1:0]   cmd,
      input logic [POS_W-1:0]   pos,
      input logic [VALUE_W-1:0] val
   );
      list_result_type r;
      int              p;
      r.read_data = '0;
      r.status    = ST_OK;
      p           = int'(pos);
      case (cmd)
         CMD_APPEND: begin
            if (shadow_fill >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_entries[shadow_fill] = val;
               shadow_fill++;
            end
         end
         CMD_INSERT: begin
            if (p > shadow_fill) begin
               r.status = ST_RANGE;
            end else if (shadow_fill >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = shadow_fill; i > p; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p] = val;
               shadow_fill++;
            end
         end
         CMD_REMOVE: begin
            if (p >= shadow_fill) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = p; i + 1 < shadow_fill; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               shadow_fill--;
            end
         end
         CMD_OVERWRITE: begin
            if (p >= shadow_fill) r.status = ST_RANGE;
            else shadow_entries[p] = val;
         end
         CMD_READ: begin
            if (p >= shadow_fill) r.status = ST_RANGE;
            else r.read_data = shadow_entries[p];
         end
         CMD_CLEAR: begin
            shadow_fill = 0;
         end
         default: begin
         end
      endcase
      r.count = COUNT_W'(shadow_fill);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard_step
      list_result_type want;
      if (reset) begin
         expected_q.delete();
         shadow_fill = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, expected nothing, actual %h/%0d/%0d",
                        $time, rsp_mon.read_data, rsp_mon.count, rsp_mon.status);
            end else begin
               want = expected_q.pop_front();
               check_field("read_data", want.read_data, rsp_mon.read_data);
               check_field("count", VALUE_W'(want.count), VALUE_W'(rsp_mon.count));
               check_field("status", VALUE_W'(want.status), VALUE_W'(rsp_mon.status));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.insert(expected_q.size(),
                              apply_list_command(req_mon.command, req_mon.position,
                                                 req_mon.value));
      end
      fail_count <= errors;
      pending    <= expected_q.size();
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the indexed list buffer. A short directed run
// covers the edge cases, then random episodes grow, shrink, mix and fill
// the list, with random idling on both channels and long result stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import ilb_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
   localparam int LIST_DEPTH   = DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1450;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   logic req_fast;
   logic rsp_fast;
   int   est_len;

   ilb_req_if req_if ();
   ilb_rsp_if rsp_if ();

   indexed_list_buffer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ilb_list_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   // approximate length, used to steer positions and to fill the list
   function automatic void track_length(input logic [CMD_W-1:0] cmd,
                                        input logic [POS_W-1:0] pos);
      case (cmd)
         CMD_APPEND: if (est_len < LIST_DEPTH) est_len++;
         CMD_INSERT: if (int'(pos) <= est_len && est_len < LIST_DEPTH) est_len++;
         CMD_REMOVE: if (int'(pos) < est_len) est_len--;
         CMD_CLEAR:  est_len = 0;
         default: begin
         end
      endcase
   endfunction

   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid    <= 1'b1;
      req_if.command  <= cmd;
      req_if.position <= pos;
      req_if.value    <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      track_length(cmd, pos);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_pos(input logic [CMD_W-1:0] cmd);
      if ($urandom_range(0, 99) < 15) return POS_W'($urandom);
      if (cmd == CMD_INSERT)
         return POS_W'($urandom_range(0, (est_len >= LIST_DEPTH) ? LIST_DEPTH - 1 : est_len));
      if (est_len == 0) return '0;
      return POS_W'($urandom_range(0, est_len - 1));
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(input int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         0: begin
            if (r < 45) return CMD_APPEND;
            if (r < 80) return CMD_INSERT;
            if (r < 90) return CMD_READ;
            return CMD_OVERWRITE;
         end
         1: begin
            if (r < 65) return CMD_REMOVE;
            if (r < 85) return CMD_READ;
            return CMD_OVERWRITE;
         end
         default: begin
            if (r < 3) return CMD_CLEAR;
            if (r < 6) return (r < 5) ? CMD_SPARE_A : CMD_SPARE_B;
            if (r < 20) return CMD_APPEND;
            if (r < 36) return CMD_INSERT;
            if (r < 52) return CMD_REMOVE;
            if (r < 72) return CMD_OVERWRITE;
            return CMD_READ;
         end
      endcase
   endfunction

   // result side: per-result stalls, bursts without stalls, two long holds
   initial begin : result_side
      int wait_left;
      int hold_left;
      int taken;
      wait_left = 0;
      hold_left = 0;
      taken     = 0;
      rsp_fast  = 1'b0;
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            taken++;
            if (taken == 300 || taken == 1100) hold_left = 250;
            if ($urandom_range(0, 99) < 3) rsp_fast = ~rsp_fast;
            wait_left = rsp_fast ? 0 : $urandom_range(0, 11);
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : request_side
      int issued;
      int mode;
      int run_len;
      int wait_cycles;
      logic [CMD_W-1:0] cmd;
      req_if.valid    = 1'b0;
      req_if.command  = '0;
      req_if.position = '0;
      req_if.value    = '0;
      reset    = 1'b1;
      req_fast = 1'b0;
      est_len  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty list, ends, middle, out of range, spare codes, clear
      send_cmd(CMD_READ, 6'd0, '0);
      send_cmd(CMD_REMOVE, 6'd0, '0);
      send_cmd(CMD_OVERWRITE, 6'd5, 32'h1);
      send_cmd(CMD_INSERT, 6'd1, 32'h2);
      send_cmd(CMD_INSERT, 6'd0, 32'hFFFF_FFFF);
      send_cmd(CMD_APPEND, 6'd0, 32'h0);
      send_cmd(CMD_INSERT, 6'd2, 32'hA5A5_A5A5);
      send_cmd(CMD_INSERT, 6'd1, 32'h1234_5678);
      for (int i = 0; i < 4; i++) send_cmd(CMD_READ, POS_W'(i), '0);
      send_cmd(CMD_OVERWRITE, 6'd3, 32'h8000_0001);
      send_cmd(CMD_REMOVE, 6'd1, '0);
      send_cmd(CMD_REMOVE, 6'd2, '0);
      send_cmd(CMD_READ, 6'd63, '0);
      send_cmd(CMD_INSERT, 6'd63, 32'h3);
      send_cmd(CMD_SPARE_A, 6'd63, 32'hFFFF_FFFF);
      send_cmd(CMD_SPARE_B, 6'd0, 32'h0);
      send_cmd(CMD_READ, 6'd1, '0);
      send_cmd(CMD_CLEAR, 6'd0, '0);
      send_cmd(CMD_READ, 6'd0, '0);
      send_cmd(CMD_APPEND, 6'd0, 32'h5555_5555);
      send_cmd(CMD_READ, 6'd0, '0);

      // random episodes; the first always fills the list to the top
      issued = 0;
      mode   = 3;
      while (issued < RANDOM_ITEMS) begin
         req_fast = ($urandom_range(0, 3) == 0);
         if (mode == 3) begin
            while (est_len < LIST_DEPTH) begin
               send_cmd(CMD_APPEND, POS_W'($urandom), pick_value());
               issued++;
            end
            run_len = $urandom_range(6, 20);
            for (int i = 0; i < run_len; i++) begin
               cmd = pick_cmd(($urandom_range(0, 1) == 0) ? 0 : 2);
               send_cmd(cmd, pick_pos(cmd), pick_value());
               issued++;
            end
         end else begin
            run_len = $urandom_range(10, 80);
            for (int i = 0; i < run_len; i++) begin
               cmd = pick_cmd(mode);
               send_cmd(cmd, pick_pos(cmd), pick_value());
               issued++;
            end
         end
         mode = $urandom_range(0, 19);
         mode = (mode < 7) ? 0 : (mode < 11) ? 1 : (mode < 18) ? 2 : 3;
      end

      @(negedge clock);
      req_if.valid <= 1'b0;

      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
